@@ src/ips_patch_stream_parser_defines.svh @@
// assertion macros for the ips patch stream parser
// used by the top level only, no other dependencies
`ifndef IPS_PATCH_STREAM_PARSER_DEFINES_SVH
`define IPS_PATCH_STREAM_PARSER_DEFINES_SVH

// same-cycle implication
`define IPSP_ASSERT_IMP(lbl, clk, rst_n, pre, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (con)) \
		else $error(msg);

// next-cycle implication
`define IPSP_ASSERT_NXT(lbl, clk, rst_n, pre, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (con)) \
		else $error(msg);

`endif

@@ src/ipsp_pkg.sv @@
// shared types, codes and constants of the ips patch stream parser
// no dependencies
package ipsp_pkg;

	localparam int unsigned ADDR_W = 25;
	localparam int unsigned OFS_W  = 24;
	localparam int unsigned LEN_W  = 16;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned KIND_W = 3;

	localparam int unsigned HDR_LEN = 5;
	localparam logic [OFS_W-1:0] EOF_MARK = 24'h454F46;

	localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_FILL   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_OK     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_BADHDR = 3'd3;
	localparam logic [KIND_W-1:0] KIND_TRUNC  = 3'd4;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QIDX_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		OP_WRITE,
		OP_FILL,
		OP_GROW,
		OP_OK,
		OP_BADHDR,
		OP_TRUNC
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  run;
		logic [BYTE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [BYTE_W-1:0] hdr_byte(input logic [2:0] idx);
		logic [BYTE_W-1:0] b;
		case (idx)
			3'd0: b = 8'h50;
			3'd1: b = 8'h41;
			3'd2: b = 8'h54;
			3'd3: b = 8'h43;
			3'd4: b = 8'h48;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

@@ src/ipsp_channels.sv @@
// valid/ready channel interfaces: patch bytes in, results out, config write
// depends on ipsp_pkg for widths
interface ipsp_byte_if;
	logic                           valid;
	logic                           ready;
	logic [ipsp_pkg::BYTE_W-1:0]    patch_byte;
	logic                           stream_end;
	modport source (output valid, output patch_byte, output stream_end, input ready);
	modport sink   (input valid, input patch_byte, input stream_end, output ready);
endinterface

interface ipsp_result_if;
	logic                           valid;
	logic                           ready;
	logic [ipsp_pkg::KIND_W-1:0]    kind;
	logic [ipsp_pkg::ADDR_W-1:0]    target_address;
	logic [ipsp_pkg::LEN_W-1:0]     run_length;
	logic [ipsp_pkg::BYTE_W-1:0]    data_value;
	logic [ipsp_pkg::ADDR_W-1:0]    image_size;
	modport source (output valid, output kind, output target_address, output run_length,
		output data_value, output image_size, input ready);
	modport sink   (input valid, input kind, input target_address, input run_length,
		input data_value, input image_size, output ready);
endinterface

interface ipsp_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ipsp_pkg::ADDR_W-1:0]    base_image_size;
	modport source (output valid, output base_image_size, input ready);
	modport sink   (input valid, input base_image_size, output ready);
endinterface

@@ src/ipsp_front.sv @@
// front end: accepts patch bytes, parses header and records, emits commands
// depends on ipsp_pkg and ipsp_byte_if
module ipsp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	ipsp_byte_if.sink            patch,
	input  ipsp_pkg::q_status_t  qst,
	output logic                 push,
	output ipsp_pkg::cmd_t       cmd
);

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_OFFSET = 3'd1;
	localparam logic [2:0] PH_LENGTH = 3'd2;
	localparam logic [2:0] PH_DATA   = 3'd3;
	localparam logic [2:0] PH_RUNLEN = 3'd4;
	localparam logic [2:0] PH_FILL   = 3'd5;
	localparam logic [2:0] PH_DONE   = 3'd6;

	localparam logic [2:0] HDR_LAST = 3'(ipsp_pkg::HDR_LEN - 1);

	logic [2:0]                  phase_q, phase_d;
	logic [2:0]                  field_q, field_d;
	logic [ipsp_pkg::OFS_W-1:0]  ofs_q, ofs_d;
	logic [ipsp_pkg::LEN_W-1:0]  len_q, len_d;
	logic [ipsp_pkg::LEN_W-1:0]  done_q, done_d;

	logic                        accept;
	logic [ipsp_pkg::BYTE_W-1:0] b;
	logic [ipsp_pkg::OFS_W-1:0]  ofs_shift;
	logic [ipsp_pkg::LEN_W-1:0]  len_shift;
	logic [ipsp_pkg::LEN_W-1:0]  done_inc;
	logic [ipsp_pkg::ADDR_W-1:0] ofs_ext;
	logic [ipsp_pkg::ADDR_W-1:0] data_addr;

	assign patch.ready = !qst.full;
	assign accept      = patch.valid && patch.ready;
	assign b           = patch.patch_byte;
	assign ofs_shift   = {ofs_q[ipsp_pkg::OFS_W-ipsp_pkg::BYTE_W-1:0], b};
	assign len_shift   = {len_q[ipsp_pkg::LEN_W-ipsp_pkg::BYTE_W-1:0], b};
	assign done_inc    = done_q + 16'd1;
	assign ofs_ext     = {1'b0, ofs_q};
	assign data_addr   = ofs_ext + {9'd0, done_q};

	always_comb begin
		phase_d   = phase_q;
		field_d   = field_q;
		ofs_d     = ofs_q;
		len_d     = len_q;
		done_d    = done_q;
		push      = 1'b0;
		cmd       = '0;
		cmd.op    = ipsp_pkg::OP_WRITE;
		if (accept && phase_q != PH_DONE) begin
			if (patch.stream_end) begin
				phase_d = PH_DONE;
				push    = 1'b1;
				if (phase_q == PH_HEADER)
					cmd.op = ipsp_pkg::OP_BADHDR;
				else if (phase_q == PH_OFFSET && field_q == 3'd0)
					cmd.op = ipsp_pkg::OP_OK;
				else
					cmd.op = ipsp_pkg::OP_TRUNC;
			end else begin
				unique case (phase_q)
					PH_HEADER: begin
						if (b != ipsp_pkg::hdr_byte(field_q)) begin
							phase_d = PH_DONE;
							push    = 1'b1;
							cmd.op  = ipsp_pkg::OP_BADHDR;
						end else if (field_q == HDR_LAST) begin
							phase_d = PH_OFFSET;
							field_d = 3'd0;
						end else begin
							field_d = field_q + 3'd1;
						end
					end
					PH_OFFSET: begin
						ofs_d = ofs_shift;
						if (field_q == 3'd2) begin
							field_d = 3'd0;
							if (ofs_shift == ipsp_pkg::EOF_MARK) begin
								phase_d = PH_DONE;
								push    = 1'b1;
								cmd.op  = ipsp_pkg::OP_OK;
							end else begin
								phase_d = PH_LENGTH;
								len_d   = '0;
							end
						end else begin
							field_d = field_q + 3'd1;
						end
					end
					PH_LENGTH: begin
						len_d = len_shift;
						if (field_q == 3'd1) begin
							field_d = 3'd0;
							done_d  = '0;
							if (len_shift == '0) begin
								phase_d = PH_RUNLEN;
							end else begin
								phase_d  = PH_DATA;
								push     = 1'b1;
								cmd.op   = ipsp_pkg::OP_GROW;
								cmd.addr = ofs_ext;
								cmd.run  = len_shift;
							end
						end else begin
							field_d = field_q + 3'd1;
						end
					end
					PH_DATA: begin
						push      = 1'b1;
						cmd.op    = ipsp_pkg::OP_WRITE;
						cmd.addr  = data_addr;
						cmd.value = b;
						done_d    = done_inc;
						if (done_inc >= len_q) begin
							phase_d = PH_OFFSET;
							ofs_d   = '0;
						end
					end
					PH_RUNLEN: begin
						len_d = len_shift;
						if (field_q == 3'd1) begin
							field_d  = 3'd0;
							phase_d  = PH_FILL;
							push     = 1'b1;
							cmd.op   = ipsp_pkg::OP_GROW;
							cmd.addr = ofs_ext;
							cmd.run  = len_shift;
						end else begin
							field_d = field_q + 3'd1;
						end
					end
					PH_FILL: begin
						phase_d = PH_OFFSET;
						ofs_d   = '0;
						if (len_q != '0) begin
							push      = 1'b1;
							cmd.op    = ipsp_pkg::OP_FILL;
							cmd.addr  = ofs_ext;
							cmd.run   = len_q;
							cmd.value = b;
						end
					end
					default: begin
						phase_d = PH_DONE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			field_q <= '0;
			ofs_q   <= '0;
			len_q   <= '0;
			done_q  <= '0;
		end else begin
			phase_q <= phase_d;
			field_q <= field_d;
			ofs_q   <= ofs_d;
			len_q   <= len_d;
			done_q  <= done_d;
		end
	end

endmodule

@@ src/ipsp_queue.sv @@
// two-entry command queue between front and back
// depends on ipsp_pkg
module ipsp_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ipsp_pkg::cmd_t       push_cmd,
	input  logic                 pop,
	output ipsp_pkg::cmd_t       head_cmd,
	output ipsp_pkg::q_status_t  qst
);

	ipsp_pkg::cmd_t                 entry_q [ipsp_pkg::QDEPTH];
	logic [ipsp_pkg::QIDX_W-1:0]    wr_q;
	logic [ipsp_pkg::QIDX_W-1:0]    rd_q;
	logic [ipsp_pkg::QCNT_W-1:0]    cnt_q;
	logic                           do_push;
	logic                           do_pop;

	assign qst.full  = (cnt_q == ipsp_pkg::QCNT_W'(ipsp_pkg::QDEPTH));
	assign qst.empty = (cnt_q == '0);
	assign do_push   = push && !qst.full;
	assign do_pop    = pop && !qst.empty;
	assign head_cmd  = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!do_push && do_pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

@@ src/ipsp_back.sv @@
// back end: tracks the image size, takes config writes, drives the result register
// depends on ipsp_pkg, ipsp_result_if and ipsp_cfg_if
module ipsp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ipsp_pkg::cmd_t       head_cmd,
	input  ipsp_pkg::q_status_t  qst,
	output logic                 pop,
	ipsp_result_if.source        result,
	ipsp_cfg_if.sink             cfg
);

	logic [ipsp_pkg::ADDR_W-1:0] size_q, size_d, size_g;
	logic [ipsp_pkg::ADDR_W-1:0] grow_end;
	logic                        res_valid_q;
	logic [ipsp_pkg::KIND_W-1:0] kind_q;
	logic [ipsp_pkg::ADDR_W-1:0] addr_q;
	logic [ipsp_pkg::LEN_W-1:0]  run_q;
	logic [ipsp_pkg::BYTE_W-1:0] value_q;
	logic [ipsp_pkg::ADDR_W-1:0] img_q;
	logic                        is_grow;
	logic                        out_free;
	logic                        load;
	logic                        cfg_wr;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;
	assign is_grow   = (head_cmd.op == ipsp_pkg::OP_GROW);
	assign out_free  = !res_valid_q || result.ready;
	assign pop       = !qst.empty && (is_grow || out_free);
	assign load      = pop && !is_grow;
	assign grow_end  = head_cmd.addr + {9'd0, head_cmd.run};

	always_comb begin
		size_g = size_q;
		if (pop && is_grow && grow_end > size_q)
			size_g = grow_end;
		size_d = size_g;
		if (cfg_wr && cfg.base_image_size > size_g)
			size_d = cfg.base_image_size;
	end

	assign result.valid          = res_valid_q;
	assign result.kind           = kind_q;
	assign result.target_address = addr_q;
	assign result.run_length     = run_q;
	assign result.data_value     = value_q;
	assign result.image_size     = img_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			size_q <= size_d;
			if (load)
				res_valid_q <= 1'b1;
			else if (result.ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			unique case (head_cmd.op)
				ipsp_pkg::OP_WRITE: begin
					kind_q  <= ipsp_pkg::KIND_WRITE;
					addr_q  <= head_cmd.addr;
					run_q   <= '0;
					value_q <= head_cmd.value;
					img_q   <= '0;
				end
				ipsp_pkg::OP_FILL: begin
					kind_q  <= ipsp_pkg::KIND_FILL;
					addr_q  <= head_cmd.addr;
					run_q   <= head_cmd.run;
					value_q <= head_cmd.value;
					img_q   <= '0;
				end
				ipsp_pkg::OP_OK: begin
					kind_q  <= ipsp_pkg::KIND_OK;
					addr_q  <= '0;
					run_q   <= '0;
					value_q <= '0;
					img_q   <= size_q;
				end
				ipsp_pkg::OP_BADHDR: begin
					kind_q  <= ipsp_pkg::KIND_BADHDR;
					addr_q  <= '0;
					run_q   <= '0;
					value_q <= '0;
					img_q   <= size_q;
				end
				default: begin
					kind_q  <= ipsp_pkg::KIND_TRUNC;
					addr_q  <= '0;
					run_q   <= '0;
					value_q <= '0;
					img_q   <= size_q;
				end
			endcase
		end
	end

endmodule

@@ src/ips_patch_stream_parser.sv @@
// top level of the ips patch stream parser: front, command queue, back
// depends on ipsp_pkg, the channel interfaces and the defines header
//
//  channel  | dir | payload                                              | transaction
//  patch    | in  | patch_byte, stream_end                               | one patch byte
//  result   | out | kind, target_address, run_length, data_value, size   | one command/status
//  cfg      | in  | base_image_size                                      | one register write
//
// one patch byte per cycle while patch.ready is high; commands are queued, then registered
// the rate is set by the front parser, which updates its record registers once per byte
// reset clears parser phase, queue pointers, image size and the result valid
// a stalled result fills the two-entry queue, then patch.ready drops
// size-only commands drain from the queue even while result is stalled
`include "ips_patch_stream_parser_defines.svh"

module ips_patch_stream_parser (
	input  logic          clk,
	input  logic          arst_n,
	ipsp_byte_if.sink     patch,
	ipsp_result_if.source result,
	ipsp_cfg_if.sink      cfg
);

	ipsp_pkg::q_status_t qst;
	ipsp_pkg::cmd_t      push_cmd;
	ipsp_pkg::cmd_t      head_cmd;
	logic                push;
	logic                pop;

	ipsp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.patch  (patch),
		.qst    (qst),
		.push   (push),
		.cmd    (push_cmd)
	);

	ipsp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.qst      (qst)
	);

	ipsp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_cmd (head_cmd),
		.qst      (qst),
		.pop      (pop),
		.result   (result),
		.cfg      (cfg)
	);

	`IPSP_ASSERT_IMP(a_status_clean, clk, arst_n, result.valid && (result.kind == ipsp_pkg::KIND_OK || result.kind == ipsp_pkg::KIND_BADHDR || result.kind == ipsp_pkg::KIND_TRUNC), result.target_address == '0 && result.run_length == '0 && result.data_value == '0, "status result carries command fields")
	`IPSP_ASSERT_IMP(a_cmd_no_size, clk, arst_n, result.valid && (result.kind == ipsp_pkg::KIND_WRITE || result.kind == ipsp_pkg::KIND_FILL), result.image_size == '0, "command result carries image size")
	`IPSP_ASSERT_IMP(a_fill_nonzero, clk, arst_n, result.valid && result.kind == ipsp_pkg::KIND_FILL, result.run_length != '0, "fill result with zero run length")
	`IPSP_ASSERT_NXT(a_push_lands, clk, arst_n, push && !pop && !qst.full, !qst.empty, "queued command lost")

endmodule
